FILE: design/assert_macros.svh
// Assertion macros shared by the I2C register master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
        else $error("same-cycle assertion failed");

// Property that must hold in the cycle after its trigger.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, trig, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error("next-cycle assertion failed");

`endif

FILE: design/i2cm_pkg.sv
// Types and constants of the I2C register master.
`default_nettype none

package i2cm_pkg;

    // Command codes carried with each tick.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [6:0] DEFAULT_DEVICE_ADDRESS = 7'h68;

    // Sequencer phases, one-hot.
    typedef enum logic [15:0] {
        PH_IDLE = 16'h0001,
        PH_RS0  = 16'h0002,
        PH_ST0  = 16'h0004,
        PH_ST1  = 16'h0008,
        PH_ST2  = 16'h0010,
        PH_WL   = 16'h0020,
        PH_WH   = 16'h0040,
        PH_WAL  = 16'h0080,
        PH_WAH  = 16'h0100,
        PH_RL   = 16'h0200,
        PH_RH   = 16'h0400,
        PH_MAL  = 16'h0800,
        PH_MAH  = 16'h1000,
        PH_SP0  = 16'h2000,
        PH_SP1  = 16'h4000,
        PH_SP2  = 16'h8000
    } phase_t;

    // Which byte of the transaction is on the bus.
    typedef enum logic [2:0] {
        STG_ADDRW = 3'd0,
        STG_REG   = 3'd1,
        STG_VAL   = 3'd2,
        STG_ADDRR = 3'd3,
        STG_DATA  = 3'd4
    } stage_t;

    // Result of one tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_byte;
        logic       ack_missing;
        logic       done_res;
    } res_t;

endpackage

`default_nettype wire

FILE: design/i2cm_channels.sv
// Valid/ready channel interfaces for tick input and bus result output.
`default_nettype none

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] reg_address;
    logic [7:0] write_value;
    logic [7:0] read_length;
    logic       sda_in;

    modport source (output valid, command, reg_address, write_value, read_length, sda_in,
                    input ready);
    modport sink (input valid, command, reg_address, write_value, read_length, sda_in,
                  output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic       last_byte;
    logic       ack_missing;
    logic       done_res;

    modport source (output valid, scl_out, sda_release, busy_res, read_data, read_valid,
                    last_byte, ack_missing, done_res, input ready);
    modport sink (input valid, scl_out, sda_release, busy_res, read_data, read_valid,
                  last_byte, ack_missing, done_res, output ready);
endinterface

`default_nettype wire

FILE: design/i2cm_seq.sv
// Bus sequencer: state registers and the per-tick next-state and result logic.
`default_nettype none

module i2cm_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write_en,
    input  wire logic [6:0]     cfg_write_data,
    input  wire logic           tick,
    input  wire logic [1:0]     command,
    input  wire logic [7:0]     reg_address,
    input  wire logic [7:0]     write_value,
    input  wire logic [7:0]     read_length,
    input  wire logic           sda_in,
    output i2cm_pkg::res_t      res
);
    import i2cm_pkg::*;

    logic [6:0] dev_addr_reg;
    phase_t     phase_reg, phase_next;
    stage_t     stage_reg, stage_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [7:0] latched_reg_reg, latched_reg_next;
    logic [7:0] latched_val_reg, latched_val_next;
    logic       is_read_reg, is_read_next;
    logic       nack_reg, nack_next;

    // Device address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEFAULT_DEVICE_ADDRESS;
        end
        else if (cfg_write_en)
        begin
            dev_addr_reg <= cfg_write_data;
        end
    end

    // Next state and bus levels for one tick.
    always_comb
    begin
        phase_t     cur;
        logic       start;
        logic       bitv;
        logic [7:0] bl_dec;

        start = (phase_reg == PH_IDLE) && ((command == CMD_WRITE) || (command == CMD_READ));

        phase_next       = phase_reg;
        stage_next       = stage_reg;
        bit_index_next   = bit_index_reg;
        bytes_left_next  = bytes_left_reg;
        shift_byte_next  = shift_byte_reg;
        latched_reg_next = latched_reg_reg;
        latched_val_next = latched_val_reg;
        is_read_next     = is_read_reg;
        nack_next        = nack_reg;
        bitv             = 1'b1;
        bl_dec           = bytes_left_reg;

        res             = '0;
        res.scl_out     = 1'b1;
        res.sda_release = 1'b1;

        // A new transaction latches its operands and enters the start at once.
        cur = phase_reg;
        if (start)
        begin
            latched_reg_next = reg_address;
            latched_val_next = write_value;
            bytes_left_next  = read_length;
            is_read_next     = (command == CMD_READ);
            nack_next        = 1'b0;
            stage_next       = STG_ADDRW;
            cur              = PH_ST0;
        end
        res.busy_res = (cur != PH_IDLE);

        case (cur)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RS0:
            begin
                res.scl_out = 1'b0;
                phase_next  = PH_ST0;
            end
            PH_ST0:
            begin
                phase_next = PH_ST1;
            end
            PH_ST1:
            begin
                res.sda_release = 1'b0;
                phase_next      = PH_ST2;
            end
            PH_ST2:
            begin
                res.scl_out     = 1'b0;
                res.sda_release = 1'b0;
                shift_byte_next = {dev_addr_reg, stage_reg == STG_ADDRR};
                bit_index_next  = 3'd7;
                phase_next      = PH_WL;
            end
            PH_WL:
            begin
                res.scl_out     = 1'b0;
                res.sda_release = shift_byte_reg[bit_index_reg];
                phase_next      = PH_WH;
            end
            PH_WH:
            begin
                res.sda_release = shift_byte_reg[bit_index_reg];
                if (bit_index_reg == 3'd0)
                begin
                    phase_next = PH_WAL;
                end
                else
                begin
                    bit_index_next = bit_index_reg - 3'd1;
                    phase_next     = PH_WL;
                end
            end
            PH_WAL:
            begin
                res.scl_out = 1'b0;
                phase_next  = PH_WAH;
            end
            PH_WAH:
            begin
                if (sda_in)
                begin
                    nack_next = 1'b1;
                end
                // Pick the byte that follows the acknowledged one.
                if (stage_reg == STG_ADDRW)
                begin
                    stage_next      = STG_REG;
                    shift_byte_next = latched_reg_reg;
                    bit_index_next  = 3'd7;
                    phase_next      = PH_WL;
                end
                else if (stage_reg == STG_REG)
                begin
                    if (is_read_reg)
                    begin
                        stage_next = STG_ADDRR;
                        phase_next = PH_RS0;
                    end
                    else
                    begin
                        stage_next      = STG_VAL;
                        shift_byte_next = latched_val_reg;
                        bit_index_next  = 3'd7;
                        phase_next      = PH_WL;
                    end
                end
                else if ((stage_reg == STG_ADDRR) && (bytes_left_reg != 8'd0))
                begin
                    stage_next      = STG_DATA;
                    shift_byte_next = 8'd0;
                    bit_index_next  = 3'd7;
                    phase_next      = PH_RL;
                end
                else
                begin
                    phase_next = PH_SP0;
                end
            end
            PH_RL:
            begin
                res.scl_out = 1'b0;
                phase_next  = PH_RH;
            end
            PH_RH:
            begin
                if (sda_in)
                begin
                    shift_byte_next[bit_index_reg] = 1'b1;
                end
                if (bit_index_reg == 3'd0)
                begin
                    res.read_valid = 1'b1;
                    res.read_data  = shift_byte_next;
                    res.last_byte  = (bytes_left_reg <= 8'd1);
                    phase_next     = PH_MAL;
                end
                else
                begin
                    bit_index_next = bit_index_reg - 3'd1;
                    phase_next     = PH_RL;
                end
            end
            PH_MAL:
            begin
                res.scl_out     = 1'b0;
                res.sda_release = (bytes_left_reg <= 8'd1);
                phase_next      = PH_MAH;
            end
            PH_MAH:
            begin
                bitv            = (bytes_left_reg <= 8'd1);
                res.sda_release = bitv;
                if (bytes_left_reg != 8'd0)
                begin
                    bl_dec = bytes_left_reg - 8'd1;
                end
                bytes_left_next = bl_dec;
                if (bl_dec == 8'd0)
                begin
                    phase_next = PH_SP0;
                end
                else
                begin
                    shift_byte_next = 8'd0;
                    bit_index_next  = 3'd7;
                    phase_next      = PH_RL;
                end
            end
            PH_SP0:
            begin
                res.scl_out     = 1'b0;
                res.sda_release = 1'b0;
                phase_next      = PH_SP1;
            end
            PH_SP1:
            begin
                res.sda_release = 1'b0;
                phase_next      = PH_SP2;
            end
            PH_SP2:
            begin
                res.done_res = 1'b1;
                phase_next   = PH_IDLE;
            end
            default:
            begin
                res.busy_res = 1'b0;
                phase_next   = PH_IDLE;
            end
        endcase

        res.ack_missing = nack_next;
    end

    // State advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            stage_reg       <= STG_ADDRW;
            bit_index_reg   <= 3'd0;
            bytes_left_reg  <= 8'd0;
            shift_byte_reg  <= 8'd0;
            latched_reg_reg <= 8'd0;
            latched_val_reg <= 8'd0;
            is_read_reg     <= 1'b0;
            nack_reg        <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg       <= phase_next;
            stage_reg       <= stage_next;
            bit_index_reg   <= bit_index_next;
            bytes_left_reg  <= bytes_left_next;
            shift_byte_reg  <= shift_byte_next;
            latched_reg_reg <= latched_reg_next;
            latched_val_reg <= latched_val_next;
            is_read_reg     <= is_read_next;
            nack_reg        <= nack_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/i2cm_out.sv
// Result register that holds one tick's bus levels until the consumer takes them.
`default_nettype none

module i2cm_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           tick,
    input  wire i2cm_pkg::res_t res,
    input  wire logic           out_ready,
    output logic                take_ok,
    output logic                out_valid,
    output i2cm_pkg::res_t      out_res
);
    import i2cm_pkg::*;

    logic valid_reg;
    res_t res_reg;

    // A new tick is taken when the register is empty or drains this cycle.
    assign take_ok   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: design/i2c_register_master_top.sv
// Top level of the I2C register master: tick channel in, bus level channel out.
`default_nettype none

// I2C register master. Every input transaction is one half-bit tick and yields
// exactly one output transaction with the SCL and SDA levels for that tick, the
// busy flag, a finished read byte and the sticky missing-ACK flag. A tick that
// arrives while idle with command write or read starts that register transaction.
// One tick is accepted every clock cycle; the result is held in the output register
// and the input stalls only while that register is full and not taken. The user
// must write the device address through cfg_write_en and cfg_write_data only
// while no transaction is in flight; the block itself does not enforce this.
module i2c_register_master_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [6:0] cfg_write_data,
    i2cm_in_if.sink         in_ch,
    i2cm_out_if.source      out_ch
);
    import i2cm_pkg::*;

    logic tick;
    logic take_ok;
    res_t res;
    res_t out_res;

    assign in_ch.ready = take_ok;
    assign tick        = in_ch.valid && take_ok;

    // Sequencer.
    i2cm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .tick           (tick),
        .command        (in_ch.command),
        .reg_address    (in_ch.reg_address),
        .write_value    (in_ch.write_value),
        .read_length    (in_ch.read_length),
        .sda_in         (in_ch.sda_in),
        .res            (res)
    );

    // Output register.
    i2cm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .res       (res),
        .out_ready (out_ch.ready),
        .take_ok   (take_ok),
        .out_valid (out_ch.valid),
        .out_res   (out_res)
    );

    assign out_ch.scl_out     = out_res.scl_out;
    assign out_ch.sda_release = out_res.sda_release;
    assign out_ch.busy_res    = out_res.busy_res;
    assign out_ch.read_data   = out_res.read_data;
    assign out_ch.read_valid  = out_res.read_valid;
    assign out_ch.last_byte   = out_res.last_byte;
    assign out_ch.ack_missing = out_res.ack_missing;
    assign out_ch.done_res    = out_res.done_res;

    // Checks on the sequencer results.
`include "assert_macros.svh"
    `ASSERT_NEXT_CYCLE(a_tick_gives_result, clk, rst_n, tick, out_ch.valid)
    `ASSERT_SAME_CYCLE(a_read_while_busy, clk, rst_n, out_ch.valid && out_ch.read_valid,
                       out_ch.busy_res)
    `ASSERT_SAME_CYCLE(a_last_with_valid, clk, rst_n, out_ch.valid && out_ch.last_byte,
                       out_ch.read_valid)
    `ASSERT_SAME_CYCLE(a_done_releases, clk, rst_n, out_ch.valid && out_ch.done_res,
                       out_ch.scl_out && out_ch.sda_release)

endmodule

`default_nettype wire
